### src/mbe_pkg.sv
// shared types and constants for the mandelbrot escape counter
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

   localparam int PIX_W        = 13;
   localparam int CNT_W        = 16;
   localparam int COORD_W      = 32;
   localparam int SPAN_W       = COORD_W + 1;
   localparam int PROD_MAG_W   = PIX_W + COORD_W;
   localparam int Z_W          = 34;
   localparam int SQ_W         = 60;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int SIDE_REG_W   = 14;
   localparam int MAX_SIDE_DEF = 8192;
   localparam int QUEUE_DEPTH  = 2;

   // 2.0 in q6.28 and 4.0 in q4.56
   localparam logic signed [Z_W-1:0] Z_TWO   = Z_W'(64'd1 << 29);
   localparam logic [SQ_W-1:0]       FOUR_SQ = SQ_W'(64'd1 << 58);

   localparam logic [CSR_IDX_W-1:0] CSR_REAL_MIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REAL_MAX   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAG_MIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAG_MAX   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IMG_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IMG_HEIGHT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_ITER_LIMIT = 3'd6;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_MUL,
      B_ADD,
      B_OUT
   } back_state_type;

   typedef struct packed {
      logic [PIX_W-1:0]          x;
      logic [PIX_W-1:0]          y;
      logic signed [COORD_W-1:0] c_real;
      logic signed [COORD_W-1:0] c_imag;
   } point_type;

endpackage

`default_nettype wire

### src/mbe_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module mbe_div #(
   parameter int   MAX_SIDE = mbe_pkg::MAX_SIDE_DEF,
   localparam int  SIDE_W   = $clog2(MAX_SIDE + 1)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire logic [mbe_pkg::PROD_MAG_W-1:0] dividend,
   input  wire logic [SIDE_W-1:0]             divisor,
   output logic                               done,
   output logic [mbe_pkg::PROD_MAG_W-1:0]     quotient
);
   import mbe_pkg::*;

   localparam int STEP_W = $clog2(PROD_MAG_W + 1);

   logic [PROD_MAG_W-1:0] quo_ff, quo_in;
   logic [SIDE_W-1:0]     rem_ff, rem_in;
   logic [SIDE_W-1:0]     div_ff, div_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  run_ff, run_in;
   logic                  done_ff, done_in;

   logic [SIDE_W:0]       rem_sh;
   logic                  fits;
   logic [SIDE_W-1:0]     rem_nx;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[PROD_MAG_W-1]};
      fits   = rem_sh >= {1'b0, div_ff};
      rem_nx = fits ? SIDE_W'(rem_sh - {1'b0, div_ff}) : SIDE_W'(rem_sh);
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (load) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         step_in = STEP_W'(PROD_MAG_W);
         run_in  = 1'b1;
      end else if (run_ff) begin
         quo_in  = {quo_ff[PROD_MAG_W-2:0], fits};
         rem_in  = rem_nx;
         step_in = step_ff - STEP_W'(1);
         run_in  = step_ff != STEP_W'(1);
         done_in = step_ff == STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      step_ff <= step_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

### src/mbe_front.sv
// front end: accepts a pixel and maps it into the complex plane
`timescale 1ns / 1ps
`default_nettype none

module mbe_front #(
   parameter int   MAX_SIDE = mbe_pkg::MAX_SIDE_DEF,
   localparam int  SIDE_W   = $clog2(MAX_SIDE + 1)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [mbe_pkg::PIX_W-1:0]         pixel_x,
   input  wire logic [mbe_pkg::PIX_W-1:0]         pixel_y,
   input  wire logic signed [mbe_pkg::COORD_W-1:0] real_min,
   input  wire logic signed [mbe_pkg::COORD_W-1:0] real_max,
   input  wire logic signed [mbe_pkg::COORD_W-1:0] imag_min,
   input  wire logic signed [mbe_pkg::COORD_W-1:0] imag_max,
   input  wire logic [SIDE_W-1:0]                 side_w,
   input  wire logic [SIDE_W-1:0]                 side_h,
   output logic                                   push,
   output mbe_pkg::point_type                     push_data,
   input  wire logic                              full
);
   import mbe_pkg::*;

   localparam int PROD_W = PIX_W + 1 + SPAN_W;
   localparam int SUM_W  = PROD_MAG_W + 2;

   front_state_type state_ff, state_in;

   logic [PIX_W-1:0]          x_ff, y_ff;
   logic signed [SPAN_W-1:0]  span_re_ff, span_im_ff;
   logic [COORD_W-1:0]        base_re_ff, base_im_ff;
   logic [SIDE_W-1:0]         side_w_ff, side_h_ff;
   logic                      neg_re_ff, neg_im_ff;

   logic signed [PROD_W-1:0]  prod_re, prod_im;
   logic [PROD_W-1:0]         mag_re, mag_im;
   logic                      div_load;
   logic                      done_re, done_im;
   logic [PROD_MAG_W-1:0]     quo_re, quo_im;
   logic [SUM_W-1:0]          sum_re, sum_im;

   function automatic logic [COORD_W-1:0] sat_coord(input logic [SUM_W-1:0] v);
      logic [SUM_W-COORD_W:0] top;
      top = v[SUM_W-1:COORD_W-1];
      if (top == '0 || top == '1)
         return v[COORD_W-1:0];
      else if (v[SUM_W-1])
         return {1'b1, {(COORD_W-1){1'b0}}};
      else
         return {1'b0, {(COORD_W-1){1'b1}}};
   endfunction

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: if (start) state_in = F_MUL;
         F_MUL:  state_in = F_DIV;
         F_DIV:  if (done_re) state_in = F_PUSH;
         F_PUSH: if (!full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      busy     = state_ff != F_IDLE;
      div_load = state_ff == F_MUL;
      push     = state_ff == F_PUSH && !full;
   end

   // signed products and their magnitudes
   always_comb begin
      prod_re = $signed({1'b0, x_ff}) * span_re_ff;
      prod_im = $signed({1'b0, y_ff}) * span_im_ff;
      mag_re  = prod_re[PROD_W-1] ? PROD_W'(-prod_re) : PROD_W'(prod_re);
      mag_im  = prod_im[PROD_W-1] ? PROD_W'(-prod_im) : PROD_W'(prod_im);
   end

   // real adds the quotient, imaginary subtracts it
   always_comb begin
      sum_re = {{(SUM_W-COORD_W){base_re_ff[COORD_W-1]}}, base_re_ff}
             + (neg_re_ff ? SUM_W'(-{2'b0, quo_re}) : {2'b0, quo_re});
      sum_im = {{(SUM_W-COORD_W){base_im_ff[COORD_W-1]}}, base_im_ff}
             + (neg_im_ff ? {2'b0, quo_im} : SUM_W'(-{2'b0, quo_im}));
      push_data.x      = x_ff;
      push_data.y      = y_ff;
      push_data.c_real = sat_coord(sum_re);
      push_data.c_imag = sat_coord(sum_im);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (state_ff == F_IDLE && start) begin
         x_ff       <= pixel_x;
         y_ff       <= pixel_y;
         span_re_ff <= {real_max[COORD_W-1], real_max} - {real_min[COORD_W-1], real_min};
         span_im_ff <= {imag_max[COORD_W-1], imag_max} - {imag_min[COORD_W-1], imag_min};
         base_re_ff <= real_min;
         base_im_ff <= imag_max;
         side_w_ff  <= side_w;
         side_h_ff  <= side_h;
      end
      if (state_ff == F_MUL) begin
         neg_re_ff <= prod_re[PROD_W-1];
         neg_im_ff <= prod_im[PROD_W-1];
      end
   end

   mbe_div #(.MAX_SIDE(MAX_SIDE)) u_div_re (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .dividend (mag_re[PROD_MAG_W-1:0]),
      .divisor  (side_w_ff),
      .done     (done_re),
      .quotient (quo_re)
   );

   mbe_div #(.MAX_SIDE(MAX_SIDE)) u_div_im (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .dividend (mag_im[PROD_MAG_W-1:0]),
      .divisor  (side_h_ff),
      .done     (done_im),
      .quotient (quo_im)
   );

   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      done_re == done_im)
      else $error("dividers out of step");

endmodule

`default_nettype wire

### src/mbe_fifo.sv
// short queue of mapped points between front and back
`timescale 1ns / 1ps
`default_nettype none

module mbe_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire mbe_pkg::point_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output mbe_pkg::point_type      pop_data,
   output logic                    empty
);
   import mbe_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_Q_W = $clog2(QUEUE_DEPTH + 1);

   point_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_Q_W-1:0]   count_ff, count_in;

   always_comb begin
      full     = count_ff == CNT_Q_W'(QUEUE_DEPTH);
      empty    = count_ff == '0;
      pop_data = mem_ff[rd_ptr_ff];
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (push && !pop)
         count_in = count_ff + CNT_Q_W'(1);
      else if (pop && !push)
         count_in = count_ff - CNT_Q_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push)
         mem_ff[wr_ptr_ff] <= push_data;
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_Q_W'(QUEUE_DEPTH) && !(pop && empty))
      else $error("queue overrun or underrun");

endmodule

`default_nettype wire

### src/mbe_iter.sv
// back end: escape-time iteration, each step a multiply state then an add and compare state
`timescale 1ns / 1ps
`default_nettype none

module mbe_iter (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       empty,
   output logic                            pop,
   input  wire mbe_pkg::point_type         pop_data,
   input  wire logic [mbe_pkg::CNT_W-1:0]  iteration_limit,
   output logic                            rsp_valid,
   output logic [mbe_pkg::PIX_W-1:0]       rsp_x,
   output logic [mbe_pkg::PIX_W-1:0]       rsp_y,
   output logic [mbe_pkg::CNT_W-1:0]       rsp_count
);
   import mbe_pkg::*;

   localparam int OPND_W = 31;
   localparam int MUL_W  = 2 * OPND_W;

   back_state_type state_ff, state_in;

   logic [PIX_W-1:0]          x_ff, y_ff;
   logic signed [COORD_W-1:0] cr_ff, ci_ff;
   logic signed [Z_W-1:0]     zr_ff, zr_in, zi_ff, zi_in;
   logic [CNT_W-1:0]          n_ff, n_in;
   logic [SQ_W-1:0]           rr_ff, ii_ff;
   logic signed [SQ_W-1:0]    ri_ff;

   logic                      limit_hit, too_big, sum_over;
   logic signed [OPND_W-1:0]  zr_op, zi_op;
   logic signed [MUL_W-1:0]   rr_p, ii_p, ri_p;
   logic [SQ_W-1:0]           mag_sum;
   logic signed [SQ_W-1:0]    sq_diff;

   always_comb begin
      limit_hit = n_ff >= iteration_limit;
      too_big   = zr_ff > Z_TWO || zr_ff < -Z_TWO || zi_ff > Z_TWO || zi_ff < -Z_TWO;
      zr_op     = zr_ff[OPND_W-1:0];
      zi_op     = zi_ff[OPND_W-1:0];
      rr_p      = zr_op * zr_op;
      ii_p      = zi_op * zi_op;
      ri_p      = zr_op * zi_op;
      mag_sum   = rr_ff + ii_ff;
      sum_over  = mag_sum > FOUR_SQ;
      sq_diff   = $signed(rr_ff - ii_ff);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (!empty) state_in = B_MUL;
         B_MUL:  state_in = (limit_hit || too_big) ? B_OUT : B_ADD;
         B_ADD:  state_in = sum_over ? B_OUT : B_MUL;
         B_OUT:  state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      pop       = state_ff == B_IDLE && !empty;
      rsp_valid = state_ff == B_OUT;
      rsp_x     = x_ff;
      rsp_y     = y_ff;
      rsp_count = n_ff;
   end

   always_comb begin
      zr_in = zr_ff;
      zi_in = zi_ff;
      n_in  = n_ff;
      if (pop) begin
         zr_in = '0;
         zi_in = '0;
         n_in  = '0;
      end else if (state_ff == B_ADD && !sum_over) begin
         zr_in = Z_W'(sq_diff >>> 28) + Z_W'(cr_ff);
         zi_in = Z_W'(ri_ff >>> 27) + Z_W'(ci_ff);
         n_in  = n_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
      zr_ff <= zr_in;
      zi_ff <= zi_in;
      n_ff  <= n_in;
      if (pop) begin
         x_ff  <= pop_data.x;
         y_ff  <= pop_data.y;
         cr_ff <= pop_data.c_real;
         ci_ff <= pop_data.c_imag;
      end
      if (state_ff == B_MUL) begin
         rr_ff <= rr_p[SQ_W-1:0];
         ii_ff <= ii_p[SQ_W-1:0];
         ri_ff <= ri_p[SQ_W-1:0];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= iteration_limit)
      else $error("count beyond limit");

   a_add_after_mul: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_ADD |=> state_ff == B_MUL || state_ff == B_OUT)
      else $error("bad step order");

endmodule

`default_nettype wire

### src/mandelbrot_escape_count_top.sv
// top level of the mandelbrot escape-time counter
//
// usage: hold req_pixel_x / req_pixel_y and raise start; the beat is taken at a
// clock edge where start is high and busy is low. the front end maps the pixel
// into the complex plane (a multiply state, a divide state that waits on the
// dividers, a push state), and busy stays high until the point is pushed, which
// waits while the queue is full. mapped points wait in a two-entry queue for the
// iteration engine, which runs each iteration as a multiply state then an add
// and compare state, between an idle state and an output state, and pops the
// next point only from idle. each result beat is shown for one cycle with
// rsp_valid high; the receiver cannot stall it. results come out in accept
// order. csr_write with csr_index/csr_wdata writes a register at once; the user
// must write only while idle, the block has no check for it.
// reset clears the control state and loads the default view and limits.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_count_top #(
   parameter int MAX_SIDE = mbe_pkg::MAX_SIDE_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [mbe_pkg::PIX_W-1:0]       req_pixel_x,
   input  wire logic [mbe_pkg::PIX_W-1:0]       req_pixel_y,
   output logic                                 rsp_valid,
   output logic [mbe_pkg::PIX_W-1:0]            rsp_out_x,
   output logic [mbe_pkg::PIX_W-1:0]            rsp_out_y,
   output logic [mbe_pkg::CNT_W-1:0]            rsp_iter_count,
   input  wire logic                            csr_write,
   input  wire logic [mbe_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mbe_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mbe_pkg::*;

   localparam int SIDE_W = $clog2(MAX_SIDE + 1);

   logic signed [COORD_W-1:0] real_min_ff, real_min_in;
   logic signed [COORD_W-1:0] real_max_ff, real_max_in;
   logic signed [COORD_W-1:0] imag_min_ff, imag_min_in;
   logic signed [COORD_W-1:0] imag_max_ff, imag_max_in;
   logic [SIDE_REG_W-1:0]     width_ff, width_in;
   logic [SIDE_REG_W-1:0]     height_ff, height_in;
   logic [CNT_W-1:0]          limit_ff, limit_in;

   logic [SIDE_W-1:0]         side_w, side_h;
   logic                      push, full, pop, empty;
   point_type                 push_data, pop_data;

   always_comb begin
      real_min_in = real_min_ff;
      real_max_in = real_max_ff;
      imag_min_in = imag_min_ff;
      imag_max_in = imag_max_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      limit_in    = limit_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_REAL_MIN:   real_min_in = csr_wdata[COORD_W-1:0];
            CSR_REAL_MAX:   real_max_in = csr_wdata[COORD_W-1:0];
            CSR_IMAG_MIN:   imag_min_in = csr_wdata[COORD_W-1:0];
            CSR_IMAG_MAX:   imag_max_in = csr_wdata[COORD_W-1:0];
            CSR_IMG_WIDTH:  width_in    = csr_wdata[SIDE_REG_W-1:0];
            CSR_IMG_HEIGHT: height_in   = csr_wdata[SIDE_REG_W-1:0];
            CSR_ITER_LIMIT: limit_in    = csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         real_min_ff <= 32'hE000_0000;
         real_max_ff <= 32'h1000_0000;
         imag_min_ff <= 32'hE800_0000;
         imag_max_ff <= 32'h1800_0000;
         width_ff    <= SIDE_REG_W'(4096);
         height_ff   <= SIDE_REG_W'(4096);
         limit_ff    <= CNT_W'(1000);
      end else begin
         real_min_ff <= real_min_in;
         real_max_ff <= real_max_in;
         imag_min_ff <= imag_min_in;
         imag_max_ff <= imag_max_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         limit_ff    <= limit_in;
      end
   end

   // zero side counts as one, oversize clamps
   always_comb begin
      if (width_ff == '0)
         side_w = SIDE_W'(1);
      else if (32'(width_ff) > 32'(MAX_SIDE))
         side_w = SIDE_W'(MAX_SIDE);
      else
         side_w = SIDE_W'(width_ff);
      if (height_ff == '0)
         side_h = SIDE_W'(1);
      else if (32'(height_ff) > 32'(MAX_SIDE))
         side_h = SIDE_W'(MAX_SIDE);
      else
         side_h = SIDE_W'(height_ff);
   end

   mbe_front #(.MAX_SIDE(MAX_SIDE)) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .pixel_x   (req_pixel_x),
      .pixel_y   (req_pixel_y),
      .real_min  (real_min_ff),
      .real_max  (real_max_ff),
      .imag_min  (imag_min_ff),
      .imag_max  (imag_max_ff),
      .side_w    (side_w),
      .side_h    (side_h),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   mbe_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (empty)
   );

   mbe_iter u_iter (
      .clock           (clock),
      .reset           (reset),
      .empty           (empty),
      .pop             (pop),
      .pop_data        (pop_data),
      .iteration_limit (limit_ff),
      .rsp_valid       (rsp_valid),
      .rsp_x           (rsp_out_x),
      .rsp_y           (rsp_out_y),
      .rsp_count       (rsp_iter_count)
   );

endmodule

`default_nettype wire

### sim/tb.sv
// testbench for the mandelbrot escape-time counter: self-checking, randomized
`timescale 1ns / 1ps

module tb;
   import mbe_pkg::*;

   localparam int              SIDE_CAP    = 8192;
   localparam int              STALL_LIMIT = 1000000;
   localparam longint          Q_TWO       = 64'sd1 <<< 29;
   localparam longint          Q_FOUR_SQ   = 64'sd1 <<< 58;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   typedef struct {
      logic [PIX_W-1:0] x;
      logic [PIX_W-1:0] y;
      logic             drain_first;
   } pixel_req_t;

   typedef struct {
      logic [PIX_W-1:0] x;
      logic [PIX_W-1:0] y;
      logic [CNT_W-1:0] count;
   } pixel_result_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [PIX_W-1:0]      req_pixel_x = '0;
   logic [PIX_W-1:0]      req_pixel_y = '0;
   logic                  rsp_valid;
   logic [PIX_W-1:0]      rsp_out_x;
   logic [PIX_W-1:0]      rsp_out_y;
   logic [CNT_W-1:0]      rsp_iter_count;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // register shadow, reset values
   logic signed [COORD_W-1:0] re_lo = 32'hE000_0000;
   logic signed [COORD_W-1:0] re_hi = 32'h1000_0000;
   logic signed [COORD_W-1:0] im_lo = 32'hE800_0000;
   logic signed [COORD_W-1:0] im_hi = 32'h1800_0000;
   logic [SIDE_REG_W-1:0]     cols = 14'd4096;
   logic [SIDE_REG_W-1:0]     rows = 14'd4096;
   logic [CNT_W-1:0]          iter_limit = 16'd1000;

   pixel_req_t    pending_pixels[$];
   pixel_result_t expected_counts[$];
   int unsigned   items_sent = 0;
   int unsigned   results_seen = 0;
   int            sender_idle_pct = 0;
   int            errors = 0;
   int            settings_used = 1;
   int            max_count_seen = 0;
   int            quiet_cycles = 0;
   int            stim_cols = 4096;
   int            stim_rows = 4096;

   mandelbrot_escape_count_top #(.MAX_SIDE(SIDE_CAP)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_pixel_x(req_pixel_x),
      .req_pixel_y(req_pixel_y),
      .rsp_valid(rsp_valid),
      .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y),
      .rsp_iter_count(rsp_iter_count),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic logic [CNT_W-1:0] escape_iters(logic [PIX_W-1:0] px,
                                                     logic [PIX_W-1:0] py);
      longint rmin, rmax, imin, imax, w, h, cr, ci, zr, zi, rr, ii, ri, pxl, pyl;
      int     n;
      rmin = re_lo;
      rmax = re_hi;
      imin = im_lo;
      imax = im_hi;
      w = cols;
      h = rows;
      if (w < 1) w = 1;
      if (w > SIDE_CAP) w = SIDE_CAP;
      if (h < 1) h = 1;
      if (h > SIDE_CAP) h = SIDE_CAP;
      pxl = px;
      pyl = py;
      cr = rmin + (pxl * (rmax - rmin)) / w;
      ci = imax - (pyl * (imax - imin)) / h;
      if (cr > 64'sd2147483647) cr = 64'sd2147483647;
      if (cr < -64'sd2147483648) cr = -64'sd2147483648;
      if (ci > 64'sd2147483647) ci = 64'sd2147483647;
      if (ci < -64'sd2147483648) ci = -64'sd2147483648;
      zr = 0;
      zi = 0;
      n = 0;
      while (n < int'(iter_limit)) begin
         if ((zr < 0 ? -zr : zr) > Q_TWO || (zi < 0 ? -zi : zi) > Q_TWO) break;
         rr = zr * zr;
         ii = zi * zi;
         if (rr + ii > Q_FOUR_SQ) break;
         ri = zr * zi;
         zr = ((rr - ii) >>> 28) + cr;
         zi = (ri >>> 27) + ci;
         n++;
      end
      return n[CNT_W-1:0];
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_REAL_MIN:   re_lo = value;
         CSR_REAL_MAX:   re_hi = value;
         CSR_IMAG_MIN:   im_lo = value;
         CSR_IMAG_MAX:   im_hi = value;
         CSR_IMG_WIDTH:  cols = value[SIDE_REG_W-1:0];
         CSR_IMG_HEIGHT: rows = value[SIDE_REG_W-1:0];
         CSR_ITER_LIMIT: iter_limit = value[CNT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic add_pixel(input int x, input int y, input logic drain);
      pending_pixels.push_back('{x[PIX_W-1:0], y[PIX_W-1:0], drain});
   endtask

   // sampled away from the rising edge so a beat that is offered but not yet taken counts
   task automatic drain_pixels();
      @(negedge clock);
      while (pending_pixels.size() != 0 || start || items_sent != results_seen)
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic pick_random_setting();
      int lo, span;
      case ($urandom_range(3))
         0: begin
            write_reg(CSR_REAL_MIN, 32'hE000_0000);
            write_reg(CSR_REAL_MAX, 32'h1000_0000);
            write_reg(CSR_IMAG_MIN, 32'hE800_0000);
            write_reg(CSR_IMAG_MAX, 32'h1800_0000);
         end
         1: begin
            // zoomed window near the set
            lo = -(2 ** 29) + int'($urandom_range(5 * 2 ** 27));
            span = int'($urandom_range(2 ** 29, 2 ** 14));
            write_reg(CSR_REAL_MIN, lo);
            write_reg(CSR_REAL_MAX, lo + span);
            lo = -(3 * 2 ** 27) + int'($urandom_range(3 * 2 ** 28));
            span = int'($urandom_range(2 ** 29, 2 ** 14));
            write_reg(CSR_IMAG_MIN, lo);
            write_reg(CSR_IMAG_MAX, lo + span);
         end
         2: begin
            write_reg(CSR_REAL_MIN, $urandom);
            write_reg(CSR_REAL_MAX, $urandom);
            write_reg(CSR_IMAG_MIN, $urandom);
            write_reg(CSR_IMAG_MAX, $urandom);
         end
         default: begin
            write_reg(CSR_REAL_MIN, -(3 * 2 ** 28) + int'($urandom_range(5 * 2 ** 28)));
            write_reg(CSR_REAL_MAX, -(3 * 2 ** 28) + int'($urandom_range(5 * 2 ** 28)));
            write_reg(CSR_IMAG_MIN, -(3 * 2 ** 28) + int'($urandom_range(5 * 2 ** 28)));
            write_reg(CSR_IMAG_MAX, -(3 * 2 ** 28) + int'($urandom_range(5 * 2 ** 28)));
         end
      endcase
      stim_cols = ($urandom_range(9) == 0) ? $urandom_range(16383) : $urandom_range(8192, 1);
      stim_rows = ($urandom_range(9) == 0) ? $urandom_range(16383) : $urandom_range(8192, 1);
      write_reg(CSR_IMG_WIDTH, stim_cols);
      write_reg(CSR_IMG_HEIGHT, stim_rows);
      write_reg(CSR_ITER_LIMIT,
                ($urandom_range(15) == 0) ? $urandom_range(300) : $urandom_range(64, 1));
      if (stim_cols < 1) stim_cols = 1;
      if (stim_cols > SIDE_CAP) stim_cols = SIDE_CAP;
      if (stim_rows < 1) stim_rows = 1;
      if (stim_rows > SIDE_CAP) stim_rows = SIDE_CAP;
      settings_used++;
   endtask

   // driver
   always @(posedge clock) begin : drive_beats
      logic        taken;
      logic        holding;
      int unsigned in_flight;
      pixel_req_t  next_pixel;
      taken = start && !busy;
      holding = start && !taken;
      in_flight = items_sent - results_seen + (taken ? 1 : 0);
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (taken) begin
            expected_counts.push_back('{req_pixel_x, req_pixel_y,
                                        escape_iters(req_pixel_x, req_pixel_y)});
            items_sent <= items_sent + 1;
         end
         if (!holding && pending_pixels.size() != 0
             && $urandom_range(99) >= sender_idle_pct
             && (!pending_pixels[0].drain_first || in_flight == 0)) begin
            next_pixel = pending_pixels.pop_front();
            req_pixel_x <= next_pixel.x;
            req_pixel_y <= next_pixel.y;
            start <= 1'b1;
         end else if (!holding) begin
            start <= 1'b0;
            req_pixel_x <= PIX_W'($urandom);
            req_pixel_y <= PIX_W'($urandom);
         end
      end
   end

   // monitor
   always @(posedge clock) begin : check_beats
      pixel_result_t wanted;
      if (!reset && rsp_valid) begin
         results_seen <= results_seen + 1;
         if (int'(rsp_iter_count) > max_count_seen) max_count_seen <= rsp_iter_count;
         if (expected_counts.size() == 0) begin
            errors++;
            $display("%0t unexpected beat: expected none, got x=%0d y=%0d count=%0d",
                     $time, rsp_out_x, rsp_out_y, rsp_iter_count);
         end else begin
            wanted = expected_counts.pop_front();
            if (rsp_out_x !== wanted.x) begin
               errors++;
               $display("%0t out_x: expected %0d, got %0d", $time, wanted.x, rsp_out_x);
            end
            if (rsp_out_y !== wanted.y) begin
               errors++;
               $display("%0t out_y: expected %0d, got %0d", $time, wanted.y, rsp_out_y);
            end
            if (rsp_iter_count !== wanted.count) begin
               errors++;
               $display("%0t iter_count at (%0d,%0d): expected %0d, got %0d", $time,
                        wanted.x, wanted.y, wanted.count, rsp_iter_count);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t no beat for %0d cycles, giving up", $time, quiet_cycles);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int mode, batch, i, x, y;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // default view: corners, far pixels, interior points
      add_pixel(0, 0, 1'b0);
      add_pixel(8191, 0, 1'b0);
      add_pixel(0, 8191, 1'b0);
      add_pixel(8191, 8191, 1'b0);
      add_pixel(2731, 2048, 1'b0);
      add_pixel(1365, 2048, 1'b1);
      add_pixel(4095, 4095, 1'b0);
      drain_pixels();

      // zero limit
      write_reg(CSR_ITER_LIMIT, 32'd0);
      add_pixel(2731, 2048, 1'b0);
      add_pixel(0, 0, 1'b0);
      drain_pixels();

      // deepest limit, one point that never escapes
      write_reg(CSR_ITER_LIMIT, 32'd65535);
      add_pixel(0, 0, 1'b0);
      add_pixel(2731, 2048, 1'b0);
      drain_pixels();

      // widest view, zero width, oversized height, saturating mapping
      write_reg(CSR_REAL_MIN, 32'h8000_0000);
      write_reg(CSR_REAL_MAX, 32'h7FFF_FFFF);
      write_reg(CSR_IMAG_MIN, 32'h8000_0000);
      write_reg(CSR_IMAG_MAX, 32'h7FFF_FFFF);
      write_reg(CSR_IMG_WIDTH, 32'd0);
      write_reg(CSR_IMG_HEIGHT, 32'd16383);
      write_reg(CSR_ITER_LIMIT, 32'd8);
      settings_used += 3;
      add_pixel(0, 0, 1'b0);
      add_pixel(8191, 8191, 1'b0);
      add_pixel(1, 4096, 1'b0);
      add_pixel(0, 8191, 1'b0);
      drain_pixels();

      // reversed spans, unit sides, write to the unused index
      write_reg(CSR_REAL_MIN, 32'h0800_0000);
      write_reg(CSR_REAL_MAX, 32'hE800_0000);
      write_reg(CSR_IMAG_MIN, 32'h1000_0000);
      write_reg(CSR_IMAG_MAX, 32'hF000_0000);
      write_reg(CSR_IMG_WIDTH, 32'd1);
      write_reg(CSR_IMG_HEIGHT, 32'd1);
      write_reg(CSR_ITER_LIMIT, 32'd30);
      write_reg(CSR_SPARE, 32'hFFFF_FFFF);
      settings_used++;
      add_pixel(0, 0, 1'b0);
      add_pixel(1, 1, 1'b0);
      add_pixel(5, 3, 1'b0);
      drain_pixels();

      // random part: sender idles 22%, then 67%, then never
      for (mode = 0; mode < 3; mode++) begin
         sender_idle_pct = (mode == 0) ? 22 : (mode == 1) ? 67 : 0;
         for (batch = 0; batch < 3; batch++) begin
            pick_random_setting();
            for (i = 0; i < 50; i++) begin
               x = ($urandom_range(7) == 0) ? $urandom_range(8191) : $urandom_range(stim_cols - 1);
               y = ($urandom_range(7) == 0) ? $urandom_range(8191) : $urandom_range(stim_rows - 1);
               add_pixel(x, y, i == 25);
            end
            drain_pixels();
         end
      end

      repeat (200) @(posedge clock);
      if (expected_counts.size() != 0) begin
         errors += expected_counts.size();
         $display("%0t %0d expected beats never arrived", $time, expected_counts.size());
      end
      $display("covered %0d pixels over %0d register settings with three sender idle mixes",
               items_sent, settings_used);
      $display("deepest escape count returned %0d, %0d mismatches", max_count_seen, errors);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### sim.f
src/mbe_pkg.sv
src/mbe_div.sv
src/mbe_front.sv
src/mbe_fifo.sv
src/mbe_iter.sv
src/mandelbrot_escape_count_top.sv
sim/tb.sv
